FILE: rtl/i2c_master_byte_engine_top_assert.svh
// assertion macros shared by the i2c master byte engine rtl
// no dependencies; included inside module bodies
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/i2cm_pkg.sv
// package for the i2c master byte engine: command codes, phase timing, shared types
// no dependencies
`timescale 1ns / 1ps

package i2cm_pkg;

   // command codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // phase hold times in microseconds
   localparam logic [7:0] HOLD_BUS         = 8'd50;
   localparam logic [7:0] HOLD_WR_FIRST    = 8'd10;
   localparam logic [7:0] HOLD_BIT         = 8'd5;
   localparam logic [7:0] HOLD_BIT_SETTLE  = 8'd6;
   localparam logic [7:0] HOLD_WR_ACK      = 8'd40;
   localparam logic [7:0] HOLD_WR_END      = 8'd0;
   localparam logic [7:0] HOLD_RD_FIRST    = 8'd40;
   localparam logic [7:0] HOLD_RD_HIGH     = 8'd30;
   localparam logic [7:0] HOLD_RD_LOW      = 8'd60;
   localparam logic [7:0] HOLD_RD_ACK_LOW  = 8'd30;
   localparam logic [7:0] HOLD_RD_ACK_HIGH = 8'd50;
   localparam logic [7:0] HOLD_RD_END      = 8'd150;

   // phase positions within a command
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_FIRST       = 5'd0;
   localparam logic [POS_W-1:0] POS_BUS_MID     = 5'd1;
   localparam logic [POS_W-1:0] POS_BUS_LAST    = 5'd2;
   localparam logic [POS_W-1:0] POS_WR_BODY_END = 5'd24;
   localparam logic [POS_W-1:0] POS_WR_ACK_SET  = 5'd25;
   localparam logic [POS_W-1:0] POS_WR_ACK_HIGH = 5'd26;
   localparam logic [POS_W-1:0] POS_WR_RELEASE  = 5'd27;
   localparam logic [POS_W-1:0] POS_WR_LAST     = 5'd28;
   localparam logic [POS_W-1:0] POS_RD_BODY_END = 5'd16;
   localparam logic [POS_W-1:0] POS_RD_ACK_SET  = 5'd17;
   localparam logic [POS_W-1:0] POS_RD_ACK_HIGH = 5'd18;
   localparam logic [POS_W-1:0] POS_RD_LAST     = 5'd19;

   // sub-phase codes inside one data bit
   localparam logic [1:0] SUB_SETUP = 2'd0;
   localparam logic [1:0] SUB_HIGH  = 2'd1;
   localparam logic [1:0] SUB_LOW   = 2'd2;

   localparam logic [2:0] BIT_LSB = 3'd7;

   // sequencer position plus the command being run
   typedef struct packed {
      logic [1:0]       op;
      logic [POS_W-1:0] pos;
      logic [2:0]       bit_idx;
      logic [1:0]       sub;
      logic [7:0]       wb;
      logic             nack;
      logic [7:0]       sb;
      logic             sack;
      logic             data_line;
   } ctrl_type;

   // one pin phase plus sequencer hints
   typedef struct packed {
      logic       scl;
      logic       en;
      logic       latch;
      logic [7:0] hold;
      logic [7:0] rd;
      logic       ack;
      logic       last;
      logic       body_step;
      logic       bit_done;
   } phase_type;

endpackage

FILE: rtl/i2cm_phase_gen.sv
// pin phase decoder: maps command and sequencer position to one pin phase
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_phase_gen (
   input  i2cm_pkg::ctrl_type  ctrl,
   output i2cm_pkg::phase_type ph
);
   import i2cm_pkg::*;

   logic wr_bit;

   // msb first: bit index 0 selects bit 7
   assign wr_bit = ctrl.wb[~ctrl.bit_idx];

   always_comb begin
      ph       = '0;
      ph.en    = 1'b1;
      ph.latch = ctrl.data_line;
      case (ctrl.op)
         OP_START: begin
            ph.hold = HOLD_BUS;
            case (ctrl.pos)
               POS_FIRST: begin
                  ph.scl   = 1'b1;
                  ph.latch = 1'b1;
               end
               POS_BUS_MID: begin
                  ph.scl   = 1'b1;
                  ph.latch = 1'b0;
               end
               default: begin
                  ph.scl   = 1'b0;
                  ph.latch = 1'b0;
                  ph.last  = 1'b1;
               end
            endcase
         end
         OP_STOP: begin
            ph.hold = HOLD_BUS;
            case (ctrl.pos)
               POS_FIRST: begin
                  ph.scl   = 1'b0;
                  ph.latch = 1'b0;
               end
               POS_BUS_MID: begin
                  ph.scl   = 1'b1;
                  ph.latch = 1'b0;
               end
               default: begin
                  ph.scl   = 1'b1;
                  ph.latch = 1'b1;
                  ph.last  = 1'b1;
               end
            endcase
         end
         OP_WRITE: begin
            if (ctrl.pos == POS_FIRST) begin
               ph.hold = HOLD_WR_FIRST;
            end else if (ctrl.pos <= POS_WR_BODY_END) begin
               ph.scl       = (ctrl.sub == SUB_HIGH);
               ph.latch     = wr_bit;
               ph.body_step = 1'b1;
               ph.bit_done  = (ctrl.sub == SUB_LOW);
               // final low phase of the byte carries the extra settle time
               ph.hold = (ctrl.sub == SUB_LOW && ctrl.bit_idx == BIT_LSB) ?
                         HOLD_BIT_SETTLE : HOLD_BIT;
            end else begin
               case (ctrl.pos)
                  POS_WR_ACK_SET: begin
                     ph.latch = 1'b1;
                     ph.hold  = HOLD_WR_ACK;
                  end
                  POS_WR_ACK_HIGH: begin
                     ph.scl   = 1'b1;
                     ph.latch = 1'b1;
                     ph.hold  = HOLD_WR_ACK;
                  end
                  POS_WR_RELEASE: begin
                     ph.scl   = 1'b1;
                     ph.en    = 1'b0;
                     ph.latch = 1'b1;
                     ph.hold  = HOLD_WR_ACK;
                  end
                  default: begin
                     ph.en    = 1'b0;
                     ph.latch = 1'b1;
                     ph.hold  = HOLD_WR_END;
                     ph.ack   = ~ctrl.sack;
                     ph.last  = 1'b1;
                  end
               endcase
            end
         end
         OP_READ: begin
            if (ctrl.pos == POS_FIRST) begin
               ph.hold = HOLD_RD_FIRST;
            end else if (ctrl.pos <= POS_RD_BODY_END) begin
               ph.en        = 1'b0;
               ph.latch     = 1'b1;
               ph.body_step = 1'b1;
               ph.scl       = (ctrl.sub == SUB_SETUP);
               ph.hold      = (ctrl.sub == SUB_SETUP) ? HOLD_RD_HIGH : HOLD_RD_LOW;
               ph.bit_done  = (ctrl.sub != SUB_SETUP);
            end else begin
               ph.latch = ctrl.nack;
               case (ctrl.pos)
                  POS_RD_ACK_SET: begin
                     ph.hold = HOLD_RD_ACK_LOW;
                  end
                  POS_RD_ACK_HIGH: begin
                     ph.scl  = 1'b1;
                     ph.hold = HOLD_RD_ACK_HIGH;
                  end
                  default: begin
                     ph.hold = HOLD_RD_END;
                     ph.rd   = ctrl.sb;
                     ph.last = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            ph.hold = HOLD_BUS;
         end
      endcase
   end

endmodule

FILE: rtl/i2c_master_byte_engine_top.sv
// top level of the i2c master byte engine: command register, phase sequencer, result register
// depends on i2cm_pkg, i2cm_phase_gen and i2c_master_byte_engine_top_assert.svh
`timescale 1ns / 1ps
//
//   channel   | dir | handshake             | contents
//   ----------+-----+-----------------------+------------------------------------------
//   req_      | in  | req_valid / req_ready | one bus command per transaction
//   rsp_      | out | rsp_valid / rsp_ready | one pin phase per transaction
//
// phases: one leaves per clock unless rsp_ready stalls; start and stop end at POS_BUS_LAST,
//   write byte at POS_WR_LAST, read byte at POS_RD_LAST; the sequencer steps one position per clock
// the next command is taken in the same cycle as the last phase of the current one
// reset: synchronous, active high; sda latch returns to idle high, engine empties
// stalls: rsp_ready low with a phase held freezes the sequencer and holds the result register

module i2c_master_byte_engine_top (
   input  logic       clock,
   input  logic       reset,
   // command channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_write_byte,
   input  logic       req_send_nack,
   input  logic [7:0] req_slave_bits,
   input  logic       req_slave_ack_level,
   // phase channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_enable,
   output logic       rsp_sda_value,
   output logic [7:0] rsp_hold_us,
   output logic [7:0] rsp_read_data,
   output logic       rsp_ack_received,
   output logic       rsp_last
);
   import i2cm_pkg::*;

   `include "i2c_master_byte_engine_top_assert.svh"

   // command register
   logic [1:0]       op_ff,   op_in;
   logic [7:0]       wb_ff,   wb_in;
   logic             nack_ff, nack_in;
   logic [7:0]       sb_ff,   sb_in;
   logic             sack_ff, sack_in;

   // sequencer state
   logic             busy_ff,  busy_in;
   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [2:0]       bit_ff,   bit_in;
   logic [1:0]       sub_ff,   sub_in;
   logic             latch_ff, latch_in;   // sda output latch, kept across commands

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             scl_ff, en_ff, sda_ff, ack_ff, last_ff;
   logic [7:0]       hold_ff, rd_ff;

   ctrl_type         ctrl;
   phase_type        ph;
   logic             emit;
   logic             accept;

   assign ctrl.op        = op_ff;
   assign ctrl.pos       = pos_ff;
   assign ctrl.bit_idx   = bit_ff;
   assign ctrl.sub       = sub_ff;
   assign ctrl.wb        = wb_ff;
   assign ctrl.nack      = nack_ff;
   assign ctrl.sb        = sb_ff;
   assign ctrl.sack      = sack_ff;
   assign ctrl.data_line = latch_ff;

   i2cm_phase_gen u_phase_gen (
      .ctrl (ctrl),
      .ph   (ph)
   );

   // a phase moves into the result register when it is empty or being drained
   assign emit      = busy_ff && (!rsp_valid_ff || rsp_ready);
   // idle, or finishing the last phase of the current command this cycle
   assign req_ready = !busy_ff || (emit && ph.last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      op_in    = op_ff;
      wb_in    = wb_ff;
      nack_in  = nack_ff;
      sb_in    = sb_ff;
      sack_in  = sack_ff;
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      bit_in   = bit_ff;
      sub_in   = sub_ff;
      latch_in = latch_ff;

      if (emit) begin
         latch_in = ph.latch;
         pos_in   = pos_ff + 1'b1;
         if (ph.body_step) begin
            if (ph.bit_done) begin
               sub_in = SUB_SETUP;
               bit_in = bit_ff + 1'b1;
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         if (ph.last) begin
            busy_in = 1'b0;
         end
      end

      if (accept) begin
         op_in   = req_operation;
         wb_in   = req_write_byte;
         nack_in = req_send_nack;
         sb_in   = req_slave_bits;
         sack_in = req_slave_ack_level;
         busy_in = 1'b1;
         pos_in  = POS_FIRST;
         bit_in  = '0;
         sub_in  = SUB_SETUP;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= POS_FIRST;
         bit_ff       <= '0;
         sub_ff       <= SUB_SETUP;
         latch_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         bit_ff       <= bit_in;
         sub_ff       <= sub_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      wb_ff   <= wb_in;
      nack_ff <= nack_in;
      sb_ff   <= sb_in;
      sack_ff <= sack_in;
      if (emit) begin
         scl_ff  <= ph.scl;
         en_ff   <= ph.en;
         sda_ff  <= ph.en & ph.latch;   // released line reads as low
         hold_ff <= ph.hold;
         rd_ff   <= ph.rd;
         ack_ff  <= ph.ack;
         last_ff <= ph.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = scl_ff;
   assign rsp_sda_enable   = en_ff;
   assign rsp_sda_value    = sda_ff;
   assign rsp_hold_us      = hold_ff;
   assign rsp_read_data    = rd_ff;
   assign rsp_ack_received = ack_ff;
   assign rsp_last         = last_ff;

   // checks

   // a released sda line never shows a driven high level
   `I2CM_ASSERT_NOW(a_released_low, clock, reset, rsp_valid_ff && !en_ff, !sda_ff, "sda high while released")

   // the sequencer never runs past the longest command
   `I2CM_ASSERT_NOW(a_pos_range, clock, reset, busy_ff, pos_ff <= POS_WR_LAST, "phase position out of range")

   // a new command always starts from its first phase
   `I2CM_ASSERT_NEXT(a_start_pos, clock, reset, accept, busy_ff && pos_ff == POS_FIRST, "command did not restart sequencer")

   // the final phase lands at the fixed length of each command
   `I2CM_ASSERT_NOW(a_last_pos, clock, reset, emit && ph.last, (op_ff == OP_START && pos_ff == POS_BUS_LAST) || (op_ff == OP_STOP && pos_ff == POS_BUS_LAST) || (op_ff == OP_WRITE && pos_ff == POS_WR_LAST) || (op_ff == OP_READ && pos_ff == POS_RD_LAST), "command length mismatch")

endmodule

FILE: tb/tb_top.sv
// self-checking bench for the i2c master byte engine: directed command table, then random
// bus transfers, every pin phase checked against an in-bench phase predictor
// depends on i2cm_pkg and i2c_master_byte_engine_top
`timescale 1ns / 1ps

module tb_top;
   import i2cm_pkg::*;

   // one bus command as it sits on the req_ channel
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] wb;
      logic       nack;
      logic [7:0] sb;
      logic       sack;
   } cmd_type;

   // one pin phase as it leaves on the rsp_ channel
   typedef struct packed {
      logic       scl;
      logic       en;
      logic       val;
      logic [7:0] hold;
      logic [7:0] rd;
      logic       ack;
      logic       last;
   } pin_phase_type;

   // directed row: the command, plus an optional hand-typed final phase
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] wb;
      logic       nack;
      logic [7:0] sb;
      logic       sack;
      logic       typed;
      logic       f_scl;
      logic       f_en;
      logic       f_val;
      logic [7:0] f_hold;
      logic [7:0] f_rd;
      logic       f_ack;
   } dir_row_type;

   localparam int DIR_N       = 19;
   localparam int RANDOM_CMDS = 240;
   localparam int PRINT_MAX   = 25;

   // op, wb, nack, sb, sack, typed, then the final phase: scl, en, val, hold, rd, ack
   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      // stop straight out of reset: any command order is legal
      '{OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'd50,  8'h00, 1'b0},
      '{OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd50,  8'h00, 1'b0},
      // repeated start with every ignored field high
      '{OP_START, 8'hff, 1'b1, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      // write after start: first phase carries the low latch from start
      '{OP_WRITE, 8'h00, 1'b1, 8'hff, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b1},
      '{OP_WRITE, 8'hff, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_WRITE, 8'ha5, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      // read after write: sda released, latch left high
      '{OP_READ,  8'hff, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'd150, 8'h00, 1'b0},
      // read after an acked read: latch low on the first phase
      '{OP_READ,  8'h00, 1'b1, 8'hff, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'd150, 8'hff, 1'b0},
      '{OP_WRITE, 8'h5a, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_READ,  8'h00, 1'b0, 8'h5a, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_READ,  8'h00, 1'b1, 8'ha5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_STOP,  8'h55, 1'b1, 8'haa, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd50,  8'h00, 1'b0},
      // read after stop: latch high on the first phase
      '{OP_READ,  8'h00, 1'b0, 8'h81, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_WRITE, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_WRITE, 8'h80, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_READ,  8'h00, 1'b1, 8'h7e, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0},
      '{OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00, 1'b0}
   };

   // clock and reset
   logic       clock = 1'b0;
   logic       reset = 1'b1;

   // command channel, all driven from time zero
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation = OP_START;
   logic [7:0] req_write_byte = 8'h00;
   logic       req_send_nack = 1'b0;
   logic [7:0] req_slave_bits = 8'h00;
   logic       req_slave_ack_level = 1'b0;

   // phase channel
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_enable;
   logic       rsp_sda_value;
   logic [7:0] rsp_hold_us;
   logic [7:0] rsp_read_data;
   logic       rsp_ack_received;
   logic       rsp_last;

   // predicted pin phases, oldest first
   pin_phase_type expected_phases [$];

   // predictor copy of the bus lines
   logic       line_scl;
   logic       line_sda_en;
   logic       line_sda_latch;

   // run bookkeeping
   int         mismatches = 0;
   int         phases_checked = 0;
   int         accepted_cmds = 0;
   int         op_count [4] = '{0, 0, 0, 0};
   int         writes_acked = 0;
   int         writes_nacked = 0;
   bit         pressure_done = 1'b0;
   int         send_calm_left = 0;
   bit         send_calm = 1'b0;

   i2c_master_byte_engine_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_write_byte      (req_write_byte),
      .req_send_nack       (req_send_nack),
      .req_slave_bits      (req_slave_bits),
      .req_slave_ack_level (req_slave_ack_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_scl_level       (rsp_scl_level),
      .rsp_sda_enable      (rsp_sda_enable),
      .rsp_sda_value       (rsp_sda_value),
      .rsp_hold_us         (rsp_hold_us),
      .rsp_read_data       (rsp_read_data),
      .rsp_ack_received    (rsp_ack_received),
      .rsp_last            (rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- phase predictor

   // move the predicted bus lines
   function void set_lines(input logic scl, input logic en, input logic sda);
      line_scl       = scl;
      line_sda_en    = en;
      line_sda_latch = sda;
   endfunction

   // queue one phase from the current lines; a released sda reads back as 0
   function void push_phase(input logic [7:0] hold, input logic [7:0] rd, input logic ack,
                            input logic lst);
      pin_phase_type p;
      p.scl  = line_scl;
      p.en   = line_sda_en;
      p.val  = line_sda_en ? line_sda_latch : 1'b0;
      p.hold = hold;
      p.rd   = rd;
      p.ack  = ack;
      p.last = lst;
      expected_phases.push_back(p);
   endfunction

   // expand one accepted command into its run of pin phases
   function void predict_command(input cmd_type c);
      logic [7:0] rd_shift;
      logic       b;
      rd_shift = 8'h00;
      case (c.op)
         OP_START: begin
            // sda falls while scl is high, then scl falls
            set_lines(1'b1, 1'b1, 1'b1); push_phase(8'd50, 8'h00, 1'b0, 1'b0);
            set_lines(1'b1, 1'b1, 1'b0); push_phase(8'd50, 8'h00, 1'b0, 1'b0);
            set_lines(1'b0, 1'b1, 1'b0); push_phase(8'd50, 8'h00, 1'b0, 1'b1);
         end
         OP_STOP: begin
            // sda rises while scl is high
            set_lines(1'b0, 1'b1, 1'b0); push_phase(8'd50, 8'h00, 1'b0, 1'b0);
            set_lines(1'b1, 1'b1, 1'b0); push_phase(8'd50, 8'h00, 1'b0, 1'b0);
            set_lines(1'b1, 1'b1, 1'b1); push_phase(8'd50, 8'h00, 1'b0, 1'b1);
         end
         OP_WRITE: begin
            // driver re-enabled on whatever level the latch still holds
            set_lines(1'b0, 1'b1, line_sda_latch); push_phase(8'd10, 8'h00, 1'b0, 1'b0);
            for (int i = 0; i < 8; i++) begin
               b = c.wb[7-i];
               set_lines(1'b0, 1'b1, b); push_phase(8'd5, 8'h00, 1'b0, 1'b0);
               set_lines(1'b1, 1'b1, b); push_phase(8'd5, 8'h00, 1'b0, 1'b0);
               // last bit low phase absorbs the extra settle microsecond
               set_lines(1'b0, 1'b1, b); push_phase((i == 7) ? 8'd6 : 8'd5, 8'h00, 1'b0, 1'b0);
            end
            set_lines(1'b0, 1'b1, 1'b1); push_phase(8'd40, 8'h00, 1'b0, 1'b0);
            set_lines(1'b1, 1'b1, 1'b1); push_phase(8'd40, 8'h00, 1'b0, 1'b0);
            set_lines(1'b1, 1'b0, 1'b1); push_phase(8'd40, 8'h00, 1'b0, 1'b0);
            // ack slot: slave pulling sda low means acknowledged
            set_lines(1'b0, 1'b0, 1'b1); push_phase(8'd0, 8'h00, ~c.sack, 1'b1);
            if (c.sack) writes_nacked++;
            else writes_acked++;
         end
         default: begin
            set_lines(1'b0, 1'b1, line_sda_latch); push_phase(8'd40, 8'h00, 1'b0, 1'b0);
            for (int i = 0; i < 8; i++) begin
               set_lines(1'b1, 1'b0, 1'b1);
               rd_shift = {rd_shift[6:0], c.sb[7-i]};
               push_phase(8'd30, 8'h00, 1'b0, 1'b0);
               set_lines(1'b0, 1'b0, 1'b1); push_phase(8'd60, 8'h00, 1'b0, 1'b0);
            end
            set_lines(1'b0, 1'b1, c.nack); push_phase(8'd30, 8'h00, 1'b0, 1'b0);
            set_lines(1'b1, 1'b1, c.nack); push_phase(8'd50, 8'h00, 1'b0, 1'b0);
            set_lines(1'b0, 1'b1, c.nack); push_phase(8'd150, rd_shift, 1'b0, 1'b1);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- command driver

   // offer one command after a random gap, hold it until the transaction, then predict
   task automatic drive_command(input cmd_type c);
      int gap;
      int r;
      // sender runs random stretches, some with no gaps and others gappy
      if (send_calm_left == 0) begin
         send_calm      = ($urandom_range(0, 3) == 0);
         send_calm_left = $urandom_range(4, 20);
      end
      send_calm_left--;
      r = $urandom_range(0, 99);
      if (send_calm || r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= c.op;
      req_write_byte      <= c.wb;
      req_send_nack       <= c.nack;
      req_slave_bits      <= c.sb;
      req_slave_ack_level <= c.sack;
      do @(posedge clock); while (!req_ready);
      predict_command(c);
      accepted_cmds++;
      op_count[c.op]++;
   endtask

   // a command of the given code with every other field random
   function cmd_type random_cmd(input logic [1:0] op);
      cmd_type c;
      c.op   = op;
      c.wb   = 8'($urandom_range(0, 255));
      c.nack = 1'($urandom_range(0, 1));
      c.sb   = 8'($urandom_range(0, 255));
      c.sack = 1'($urandom_range(0, 1));
      return c;
   endfunction

   initial begin : stimulus
      cmd_type       plan [$];
      cmd_type       c;
      pin_phase_type p;
      int            n;
      bit            reading;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table: typed rows pin down the final phase by hand
      for (int i = 0; i < DIR_N; i++) begin
         c = '{DIR_ROWS[i].op, DIR_ROWS[i].wb, DIR_ROWS[i].nack, DIR_ROWS[i].sb,
               DIR_ROWS[i].sack};
         drive_command(c);
         if (DIR_ROWS[i].typed) begin
            p      = expected_phases[expected_phases.size()-1];
            p.scl  = DIR_ROWS[i].f_scl;
            p.en   = DIR_ROWS[i].f_en;
            p.val  = DIR_ROWS[i].f_val;
            p.hold = DIR_ROWS[i].f_hold;
            p.rd   = DIR_ROWS[i].f_rd;
            p.ack  = DIR_ROWS[i].f_ack;
            p.last = 1'b1;
            expected_phases[expected_phases.size()-1] = p;
         end
      end

      // random part: mostly well-formed transfers with random bytes, some stray commands
      while (plan.size() < RANDOM_CMDS) begin
         if ($urandom_range(0, 4) != 0) begin
            plan.push_back(random_cmd(OP_START));
            plan.push_back(random_cmd(OP_WRITE));
            n       = $urandom_range(1, 4);
            reading = 1'($urandom_range(0, 1));
            for (int k = 0; k < n; k++) begin
               c = random_cmd(reading ? OP_READ : OP_WRITE);
               // master usually nacks only the final byte it reads
               if ($urandom_range(0, 7) != 0) c.nack = (k == n - 1);
               plan.push_back(c);
            end
            // now and then the transfer is left open, as a broken sequence
            if ($urandom_range(0, 5) != 0) plan.push_back(random_cmd(OP_STOP));
         end else begin
            plan.push_back(random_cmd(2'($urandom_range(0, 3))));
         end
      end
      foreach (plan[i]) drive_command(plan[i]);
      req_valid <= 1'b0;

      // drain, then give the engine time to show any stray phase
      while (expected_phases.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d commands: %0d start, %0d stop, %0d write, %0d read",
               accepted_cmds, op_count[OP_START], op_count[OP_STOP], op_count[OP_WRITE],
               op_count[OP_READ]);
      $display("%0d pin phases compared, %0d writes acked, %0d nacked, long stall %0s",
               phases_checked, writes_acked, writes_nacked, pressure_done ? "done" : "missed");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ---------------------------------------------------------------- phase receiver

   // random backpressure, calm stretches, and one long hold-off once traffic is flowing
   initial begin : rsp_side
      int  stall_left;
      int  calm_left;
      bit  calm;
      int  r;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      forever begin
         @(posedge clock);
         if (!pressure_done && accepted_cmds >= 60) begin
            // long enough for the engine to fill and stall the command channel
            pressure_done = 1'b1;
            stall_left    = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (calm_left == 0) begin
               calm      = ($urandom_range(0, 3) == 0);
               calm_left = $urandom_range(20, 120);
            end
            calm_left--;
            r = $urandom_range(0, 99);
            if (calm || r < 70) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               if (r >= 96) stall_left = $urandom_range(8, 30);
               else stall_left = $urandom_range(0, 3);
            end
         end
      end
   end

   // ---------------------------------------------------------------- phase checker

   function void check_field(input string fname, input int unsigned want,
                             input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PRINT_MAX)
            $display("%0t ns: %0s expected %0h actual %0h", $time, fname, want, got);
      end
   endfunction

   // compare each phase transaction with the oldest prediction
   always @(posedge clock) begin : phase_check
      pin_phase_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_phases.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_MAX)
               $display("%0t ns: phase expected none actual scl %0h sda %0h/%0h hold %0d",
                        $time, rsp_scl_level, rsp_sda_enable, rsp_sda_value, rsp_hold_us);
         end else begin
            want = expected_phases.pop_front();
            phases_checked++;
            check_field("scl_level",    want.scl,  rsp_scl_level);
            check_field("sda_enable",   want.en,   rsp_sda_enable);
            check_field("sda_value",    want.val,  rsp_sda_value);
            check_field("hold_us",      want.hold, rsp_hold_us);
            check_field("read_data",    want.rd,   rsp_read_data);
            check_field("ack_received", want.ack,  rsp_ack_received);
            check_field("last",         want.last, rsp_last);
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("timeout with %0d phases still expected", expected_phases.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: i2c_master_byte_engine_top.f
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_phase_gen.sv
rtl/i2c_master_byte_engine_top.sv
tb/tb_top.sv
